[rtl/crz_pkg.sv]
`timescale 1ns / 1ps

package crz_pkg;

    // radius width; the step state widths follow from it
    localparam int RADIUS_BITS = 10;
    localparam int X_W         = RADIUS_BITS + 1;
    localparam int Y_W         = RADIUS_BITS + 2;
    localparam int D_W         = RADIUS_BITS + 4;

    // fixed field widths
    localparam int COORD_W  = 10;
    localparam int PIX_W    = 12;
    localparam int COLOUR_W = 4;
    localparam int CALC_W   = (Y_W > PIX_W) ? Y_W : PIX_W;

    // pixels per group and the index of the last one
    localparam int              GROUP_N  = 8;
    localparam int              IDX_W    = $clog2(GROUP_N);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GROUP_N - 1);

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // item modes
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // octant colours in pixel order
    localparam logic [COLOUR_W-1:0] COLOUR [GROUP_N] = '{
        4'd4, 4'd14, 4'd2, 4'd14, 4'd12, 4'd14, 4'd15, 4'd6
    };

    // one point to be plotted eight ways
    typedef struct packed {
        logic [COORD_W-1:0]    cx;
        logic [COORD_W-1:0]    cy;
        logic [X_W-1:0]        x;
        logic signed [Y_W-1:0] y;
        logic                  done;
    } t_group;

    // queue status towards front, back and top
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

[rtl/crz_front.sv]
`timescale 1ns / 1ps

module crz_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_mode,
    input  logic [crz_pkg::COORD_W-1:0]   i_center_x,
    input  logic [crz_pkg::COORD_W-1:0]   i_center_y,
    input  logic [crz_pkg::COORD_W-1:0]   i_radius,
    input  crz_pkg::t_qstat               i_qstat,
    output logic                          o_push,
    output crz_pkg::t_group               o_group
);
    import crz_pkg::*;

    logic [X_W-1:0]        r_x, n_x;
    logic signed [Y_W-1:0] r_y, n_y;
    logic signed [D_W-1:0] r_d, n_d;
    logic [COORD_W-1:0]    r_cx, n_cx;
    logic [COORD_W-1:0]    r_cy, n_cy;
    logic                  r_active, n_active;

    logic                  accept;
    logic                  done;
    logic signed [D_W-1:0] x4, y4, r2;
    logic [RADIUS_BITS-1:0] rad;

    assign accept = i_valid & ~i_qstat.full;
    assign rad    = RADIUS_BITS'(i_radius);
    assign x4     = D_W'({r_x, 2'b00});
    assign y4     = D_W'({r_y, 2'b00});
    assign r2     = D_W'({rad, 1'b0});

    always_comb begin
        n_x      = r_x;
        n_y      = r_y;
        n_d      = r_d;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_active = r_active;
        done     = 1'b0;
        if (accept) begin
            if (i_mode == MODE_START) begin
                n_cx     = i_center_x;
                n_cy     = i_center_y;
                n_x      = '0;
                n_y      = Y_W'(rad);
                n_d      = D_W'(3) - r2;
                n_active = 1'b1;
            end else if (r_active) begin
                if (r_d <= 0) begin
                    n_d = r_d + x4 + D_W'(6);
                end else begin
                    n_d = r_d + x4 - y4 + D_W'(10);
                    n_y = r_y - Y_W'(1);
                end
                n_x      = r_x + X_W'(1);
                done     = $signed({1'b0, n_x}) > n_y;
                n_active = ~done;
            end
        end
    end

    assign o_push       = accept & ((i_mode == MODE_START) | r_active);
    assign o_group.cx   = n_cx;
    assign o_group.cy   = n_cy;
    assign o_group.x    = n_x;
    assign o_group.y    = n_y;
    assign o_group.done = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_active <= 1'b0;
        end else begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_d      <= n_d;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_active <= n_active;
        end
    end

endmodule

[rtl/crz_queue.sv]
`timescale 1ns / 1ps

module crz_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crz_pkg::t_group i_data,
    input  logic            i_pop,
    output crz_pkg::t_group o_data,
    output crz_pkg::t_qstat o_stat
);
    import crz_pkg::*;

    t_group            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, r_rp;
    logic [Q_CW-1:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push & ~o_stat.full;
    assign do_pop       = i_pop & ~o_stat.empty;
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + Q_AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/crz_back.sv]
`timescale 1ns / 1ps

module crz_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  crz_pkg::t_group                i_group,
    input  crz_pkg::t_qstat                i_qstat,
    output logic                           o_pop,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic signed [crz_pkg::PIX_W-1:0] o_pixel_x,
    output logic signed [crz_pkg::PIX_W-1:0] o_pixel_y,
    output logic [crz_pkg::COLOUR_W-1:0]   o_colour,
    output logic                           o_last_of_group,
    output logic                           o_circle_done
);
    import crz_pkg::*;

    t_group              r_grp;
    logic                r_busy, n_busy;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                out_free, advance;
    logic signed [CALC_W-1:0] cx, cy, xs, ys, sx, sy, px, py;

    assign out_free = ~o_valid | ~i_stall;
    assign advance  = r_busy & out_free;
    assign o_pop    = ~i_qstat.empty & (~r_busy | (advance & (r_idx == IDX_LAST)));

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (advance) begin
            n_idx = r_idx + IDX_W'(1);
            if (r_idx == IDX_LAST) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end
    end

    // swap x and y for the upper four octants, then pick the signs
    always_comb begin
        cx = CALC_W'({1'b0, r_grp.cx});
        cy = CALC_W'({1'b0, r_grp.cy});
        xs = CALC_W'({1'b0, r_grp.x});
        ys = CALC_W'(r_grp.y);
        sx = r_idx[2] ? ys : xs;
        sy = r_idx[2] ? xs : ys;
        px = r_idx[1] ? cx - sx : cx + sx;
        py = (r_idx[1] ^ r_idx[0]) ? cy - sy : cy + sy;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_group;
        end
        if (out_free) begin
            o_pixel_x       <= px[PIX_W-1:0];
            o_pixel_y       <= py[PIX_W-1:0];
            o_colour        <= COLOUR[r_idx];
            o_last_of_group <= (r_idx == IDX_LAST);
            o_circle_done   <= r_grp.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (out_free) begin
                o_valid <= advance;
            end
        end
    end

endmodule

[rtl/circle_rasterizer_top.sv]
`timescale 1ns / 1ps
// midpoint circle generator, eight symmetric pixels per start item or per advance item of a running circle
// path: a point passes the queue memory and the emitter's group register before its pixels
//   leave through the registered output; throughput: one pixel beat per cycle while i_stall
//   is low, eight beats per item, set by the single output port of the pixel emitter
// reset: synchronous, active low; clears step state, queue and output valid

module circle_rasterizer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_mode,
    input  logic [crz_pkg::COORD_W-1:0]      i_center_x,
    input  logic [crz_pkg::COORD_W-1:0]      i_center_y,
    input  logic [crz_pkg::COORD_W-1:0]      i_radius,
    // pixel channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [crz_pkg::PIX_W-1:0] o_pixel_x,
    output logic signed [crz_pkg::PIX_W-1:0] o_pixel_y,
    output logic [crz_pkg::COLOUR_W-1:0]     o_colour,
    output logic                             o_last_of_group,
    output logic                             o_circle_done
);
    import crz_pkg::*;

    t_group push_grp;   // point leaving the stepper
    t_group pop_grp;    // point entering the emitter
    t_qstat qstat;
    logic   push;
    logic   pop;

    // input beats are taken whenever i_valid is high and the queue has room; o_stall is independent of i_valid
    assign o_stall = qstat.full;

    // front: classifies start and advance beats, runs the decision update,
    // drops advance beats that arrive with no circle in progress
    crz_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_mode     (i_mode),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_group    (push_grp)
    );

    // two-deep queue lets the stepper run ahead while pixels drain
    crz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_grp),
        .i_pop   (pop),
        .o_data  (pop_grp),
        .o_stat  (qstat)
    );

    // back: walks the eight octants of each point, one registered beat a cycle while i_stall is low
    crz_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_group         (pop_grp),
        .i_qstat         (qstat),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_colour        (o_colour),
        .o_last_of_group (o_last_of_group),
        .o_circle_done   (o_circle_done)
    );

    // the front must never offer a point to a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("point pushed into full queue");

    // the emitter must never take from an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("point popped from empty queue");

    // the closing beat of a group carries the last octant colour
    a_last_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_group) |-> (o_colour == COLOUR[GROUP_N-1]))
        else $error("group end with wrong octant colour");

    // a stalled pixel beat is followed by the same beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_x)
            && $stable(o_pixel_y) && $stable(o_colour)))
        else $error("pixel beat changed while stalled");

endmodule

[verif/tb_circle_rasterizer_top.sv]
`timescale 1ns / 1ps

module tb_circle_rasterizer_top;

    import crz_pkg::*;

    // cycles with no beat on either side before the run is abandoned
    localparam int QUIET_LIMIT  = 4000;
    // one long receiver hold-off, long enough to back up into the item port
    localparam int HOLD_CYCLES  = 300;
    // items offered in all, directed part included
    localparam int TOTAL_ITEMS  = 250;
    // full circles are only run for radii up to this
    localparam int FULL_RUN_MAX = 40;

    // octant colours in emission order
    localparam logic [COLOUR_W-1:0] OCTANT_COLOUR [GROUP_N] = '{
        4'd4, 4'd14, 4'd2, 4'd14, 4'd12, 4'd14, 4'd15, 4'd6
    };

    typedef struct {
        logic               mode;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] r;
        bit                 drain;  // sender waits until every pixel is back
        bit                 choke;  // receiver holds off once this item is offered
    } t_circle_item;

    typedef struct {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic [COLOUR_W-1:0]     colour;
        logic                    last;
        logic                    done;
    } t_pixel;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_mode = MODE_START;
    logic [COORD_W-1:0]      i_center_x = '0;
    logic [COORD_W-1:0]      i_center_y = '0;
    logic [COORD_W-1:0]      i_radius = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [PIX_W-1:0] o_pixel_x;
    logic signed [PIX_W-1:0] o_pixel_y;
    logic [COLOUR_W-1:0]     o_colour;
    logic                    o_last_of_group;
    logic                    o_circle_done;

    // stimulus still to be offered and pixels still owed by the block
    t_circle_item item_q[$];
    t_pixel       pixel_q[$];
    t_circle_item cur_item;

    // predicted circle state
    int cur_x;
    int cur_y;
    int cur_d;
    int org_x;
    int org_y;
    bit circ_active;

    // stimulus build bookkeeping: steps left in the circle being built
    int gen_left;

    // handshake pacing
    int gap_left;
    int choke_cnt;
    int choke_seen;
    int hold_left;
    int stall_left;
    int free_left;

    int quiet_cycles;
    int err_cnt;

    circle_rasterizer_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_radius        (i_radius),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_colour        (o_colour),
        .o_last_of_group (o_last_of_group),
        .o_circle_done   (o_circle_done)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // queue a start beat; the number of advances that still plot is worked
    // out here so the random part knows when a circle has closed
    task automatic add_start(input int cx, input int cy, input int r,
                             input bit drain, input bit choke);
        t_circle_item it;
        int x;
        int y;
        int d;
        int n;
        it.mode  = MODE_START;
        it.cx    = cx[COORD_W-1:0];
        it.cy    = cy[COORD_W-1:0];
        it.r     = r[COORD_W-1:0];
        it.drain = drain;
        it.choke = choke;
        item_q.push_back(it);
        x = 0;
        y = r & ((1 << RADIUS_BITS) - 1);
        d = 3 - 2 * y;
        n = 0;
        do begin
            if (d <= 0) begin
                d += 4 * x + 6;
            end else begin
                d += 4 * x - 4 * y + 10;
                y--;
            end
            x++;
            n++;
        end while (x <= y);
        gen_left = n;
    endtask

    // queue an advance beat with random don't-care payload
    task automatic add_advance();
        t_circle_item it;
        it.mode  = MODE_ADVANCE;
        it.cx    = COORD_W'($urandom);
        it.cy    = COORD_W'($urandom);
        it.r     = COORD_W'($urandom);
        it.drain = 1'b0;
        it.choke = 1'b0;
        item_q.push_back(it);
        if (gen_left > 0) begin
            gen_left--;
        end
    endtask

    // midpoint step on the predicted state, then the eight mirrored pixels
    task automatic rasterize_item(input t_circle_item it);
        t_pixel pix;
        int     px;
        int     py;
        bit     emit;
        bit     fin;
        emit = 1'b0;
        fin  = 1'b0;
        if (it.mode == MODE_START) begin
            org_x       = int'(it.cx);
            org_y       = int'(it.cy);
            cur_x       = 0;
            cur_y       = int'(it.r) & ((1 << RADIUS_BITS) - 1);
            cur_d       = 3 - 2 * cur_y;
            circ_active = 1'b1;
            emit        = 1'b1;
        end else if (circ_active) begin
            if (cur_d <= 0) begin
                cur_d += 4 * cur_x + 6;
            end else begin
                cur_d += 4 * cur_x - 4 * cur_y + 10;
                cur_y--;
            end
            cur_x++;
            // the step that crosses the diagonal is still plotted, then stops
            fin = (cur_x > cur_y);
            if (fin) begin
                circ_active = 1'b0;
            end
            emit = 1'b1;
        end
        if (emit) begin
            for (int k = 0; k < GROUP_N; k++) begin
                case (k)
                    0: begin px = org_x + cur_x; py = org_y + cur_y; end
                    1: begin px = org_x + cur_x; py = org_y - cur_y; end
                    2: begin px = org_x - cur_x; py = org_y - cur_y; end
                    3: begin px = org_x - cur_x; py = org_y + cur_y; end
                    4: begin px = org_x + cur_y; py = org_y + cur_x; end
                    5: begin px = org_x + cur_y; py = org_y - cur_x; end
                    6: begin px = org_x - cur_y; py = org_y - cur_x; end
                    default: begin px = org_x - cur_y; py = org_y + cur_x; end
                endcase
                // coordinates wrap to the pixel port width
                pix.px     = px[PIX_W-1:0];
                pix.py     = py[PIX_W-1:0];
                pix.colour = OCTANT_COLOUR[k];
                pix.last   = (k == GROUP_N - 1);
                pix.done   = fin;
                pixel_q.push_back(pix);
            end
        end
    endtask

    // item driver: predicts on each accepted beat, then offers the next item
    // after a random gap; a stalled beat is held unchanged
    always @(posedge i_clk) begin
        logic nxt_valid;
        int   sel;
        nxt_valid = i_valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                rasterize_item(cur_item);
                nxt_valid = 1'b0;
                // mostly back to back, a few long pauses
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    gap_left = 0;
                end else if (sel < 90) begin
                    gap_left = $urandom_range(1, 3);
                end else if (sel < 97) begin
                    gap_left = $urandom_range(4, 10);
                end else begin
                    gap_left = $urandom_range(15, 50);
                end
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (item_q.size() > 0 &&
                             !(item_q[0].drain && pixel_q.size() > 0)) begin
                    cur_item  = item_q.pop_front();
                    nxt_valid = 1'b1;
                    if (cur_item.choke) begin
                        choke_cnt++;
                    end
                end
            end
        end
        i_valid    <= nxt_valid;
        i_mode     <= cur_item.mode;
        i_center_x <= cur_item.cx;
        i_center_y <= cur_item.cy;
        i_radius   <= cur_item.r;
    end

    // pixel monitor: checks each accepted beat against the oldest prediction,
    // paces the receiver stall and keeps the watchdog count
    always @(posedge i_clk) begin
        t_pixel want;
        logic   nxt_stall;
        int     sel;
        nxt_stall = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pixel_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("%0t: unexpected pixel x=%0d y=%0d colour=%0d last=%0b done=%0b",
                                 $realtime, o_pixel_x, o_pixel_y, o_colour,
                                 o_last_of_group, o_circle_done);
                    end
                end else begin
                    want = pixel_q.pop_front();
                    if (o_pixel_x !== want.px || o_pixel_y !== want.py ||
                        o_colour !== want.colour || o_last_of_group !== want.last ||
                        o_circle_done !== want.done) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("%0t: pixel mismatch", $realtime);
                            $display("  expected x=%0d y=%0d colour=%0d last=%0b done=%0b",
                                     want.px, want.py, want.colour, want.last, want.done);
                            $display("  actual   x=%0d y=%0d colour=%0d last=%0b done=%0b",
                                     o_pixel_x, o_pixel_y, o_colour,
                                     o_last_of_group, o_circle_done);
                        end
                    end
                end
            end

            // watchdog: cycles with no beat on either port
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end

            // receiver pacing: one long hold-off on request, otherwise
            // alternating free runs and mostly short stalls
            if (choke_seen != choke_cnt) begin
                choke_seen = choke_cnt;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end else if (free_left > 0) begin
                free_left--;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 45) begin
                    free_left = $urandom_range(1, 30);
                end else if (sel < 50) begin
                    free_left = $urandom_range(60, 120);
                end else if (sel < 85) begin
                    stall_left = $urandom_range(0, 1);
                    nxt_stall  = 1'b1;
                end else if (sel < 97) begin
                    stall_left = $urandom_range(2, 7);
                    nxt_stall  = 1'b1;
                end else begin
                    stall_left = $urandom_range(20, 60);
                    nxt_stall  = 1'b1;
                end
            end
        end
        i_stall <= nxt_stall;
    end

    // abandon the run if the ports go quiet for too long
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int iter;
        int sel;
        int r;
        int n;

        // directed: idle advance straight out of reset
        add_advance();
        // radius zero at the origin, negative coordinates on the closing step
        add_start(0, 0, 0, 1'b0, 1'b0);
        add_advance();
        add_advance();
        // largest center and radius
        add_start(1023, 1023, 1023, 1'b0, 1'b0);
        repeat (3) add_advance();
        // restart while that circle is still running, far negative columns
        add_start(0, 1023, 1023, 1'b0, 1'b0);
        repeat (2) add_advance();
        // radius one closes in a single step, then an idle advance
        add_start(1023, 0, 1, 1'b0, 1'b0);
        add_advance();
        add_advance();
        // small circle run to completion, both decision branches
        add_start(512, 512, 3, 1'b0, 1'b0);
        repeat (3) add_advance();
        add_advance();
        // sender waits for every pixel before this start
        add_start(5, 1000, 7, 1'b1, 1'b0);
        repeat (2) add_advance();
        add_start(700, 3, 2, 1'b0, 1'b0);
        while (gen_left > 0) add_advance();

        // random: mostly whole circles, some cut short by a new start,
        // some stray advances
        iter = 0;
        while (item_q.size() < TOTAL_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                r = $urandom_range(0, 24);
            end else if (sel < 95) begin
                r = $urandom_range(25, 200);
            end else begin
                r = $urandom_range(201, 1023);
            end
            add_start($urandom_range(0, 1023), $urandom_range(0, 1023), r,
                      iter == 20, iter == 3);
            sel = $urandom_range(0, 99);
            if (sel < 65 && r <= FULL_RUN_MAX) begin
                while (gen_left > 0) add_advance();
                repeat ($urandom_range(0, 2)) add_advance();
            end else if (sel < 92) begin
                n = $urandom_range(0, (gen_left < 12) ? gen_left : 12);
                repeat (n) add_advance();
            end else begin
                repeat ($urandom_range(1, 3)) add_advance();
            end
            iter++;
        end

        // reset held from time zero, then released once
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample on the falling edge so the driver has settled
        while (item_q.size() > 0 || i_valid || pixel_q.size() > 0) begin
            @(negedge i_clk);
        end
        // margin for the pipeline registers plus one group of pixels
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && pixel_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
